// ----- src/gmc_pkg.sv -----
// ----------------------------------------------------------------------------
// gmc_pkg - memory coalescer shared definitions
// Field widths, stream bit positions, result codes and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package gmc_pkg;

	localparam int LANES           = 4;
	localparam int SLOTS           = 2;
	localparam int ADDR_W          = 32;
	localparam int CTAG_W          = 8;
	localparam int TAG_W           = 3;
	localparam int LOB_W           = 4;
	localparam int TAG_ENTRIES_DEF = 8;

	localparam logic [LOB_W-1:0] LOB_RESET = 4'd6;

	// result kinds
	localparam logic [1:0] KIND_STALL   = 2'd0;
	localparam logic [1:0] KIND_MEM_REQ = 2'd1;
	localparam logic [1:0] KIND_RSP     = 2'd2;
	localparam logic [1:0] KIND_RSP_ERR = 2'd3;

	// input beat layout
	localparam int IN_DATA_W   = 152;
	localparam int IN_MASK_LO  = 0;
	localparam int IN_ADDR_LO  = 4;
	localparam int IN_WR_BIT   = 132;
	localparam int IN_CTAG_LO  = 133;
	localparam int IN_RTAG_LO  = 141;
	localparam int IN_SMASK_LO = 144;

	// output beat layout
	localparam int OUT_DATA_W   = 88;
	localparam int OUT_CONS_BIT = 0;
	localparam int OUT_SMASK_LO = 1;
	localparam int OUT_LINE0_LO = 3;
	localparam int OUT_LINE1_LO = 35;
	localparam int OUT_MTAG_LO  = 67;
	localparam int OUT_MWR_BIT  = 70;
	localparam int OUT_RLANE_LO = 71;
	localparam int OUT_RCTAG_LO = 75;

	typedef struct packed {
		logic [SLOTS-1:0]             slot_valid;
		logic [SLOTS-1:0][ADDR_W-1:0] line;
		logic [SLOTS-1:0][LANES-1:0]  slot_lanes;
		logic [LANES-1:0]             cur;
	} grp_t;

	typedef struct packed {
		logic                        en;
		logic [CTAG_W-1:0]           core_tag;
		logic [LANES-1:0]            waiting;
		logic [SLOTS-1:0][LANES-1:0] slot_lanes;
	} alloc_t;

	typedef struct packed {
		logic             en;
		logic [LANES-1:0] served;
	} upd_t;

	typedef struct packed {
		logic                        free_found;
		logic                        rd_valid;
		logic [LANES-1:0]            rd_waiting;
		logic [CTAG_W-1:0]           rd_core_tag;
		logic [SLOTS-1:0][LANES-1:0] rd_slot_lanes;
	} tbl_stat_t;

endpackage

`default_nettype wire

// ----- src/gmc_lane_grouper.sv -----
// ----------------------------------------------------------------------------
// gmc_lane_grouper - cache line grouping of unsent lanes
// Assigns unsent active lanes to up to SLOTS lines in first-seen lane order.
// ----------------------------------------------------------------------------
`default_nettype none

module gmc_lane_grouper
	import gmc_pkg::*;
(
	input  wire logic [LANES-1:0]             mask,
	input  wire logic [LANES-1:0]             sent,
	input  wire logic [LANES-1:0][ADDR_W-1:0] addr,
	input  wire logic [LOB_W-1:0]             lob,
	output grp_t                              grp
);

	logic [ADDR_W-1:0] amask;
	logic [ADDR_W-1:0] la;
	logic              found;

	assign amask = {ADDR_W{1'b1}} << lob;

	always_comb begin
		grp   = '0;
		la    = '0;
		found = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			if (mask[i] && !sent[i]) begin
				la    = addr[i] & amask;
				found = 1'b0;
				for (int s = 0; s < SLOTS; s++) begin
					if (!found) begin
						if (grp.slot_valid[s] && grp.line[s] == la) begin
							grp.slot_lanes[s][i] = 1'b1;
							found                = 1'b1;
						end else if (!grp.slot_valid[s]) begin
							grp.slot_valid[s]    = 1'b1;
							grp.line[s]          = la;
							grp.slot_lanes[s][i] = 1'b1;
							found                = 1'b1;
						end
					end
				end
			end
		end
		for (int s = 0; s < SLOTS; s++) begin
			grp.cur = grp.cur | grp.slot_lanes[s];
		end
	end

endmodule

`default_nettype wire

// ----- src/gmc_pend_table.sv -----
// ----------------------------------------------------------------------------
// gmc_pend_table - pending read tag table
// Allocates the lowest free entry, looks up a response tag, retires lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module gmc_pend_table
	import gmc_pkg::*;
#(
	parameter  int TAG_ENTRIES = TAG_ENTRIES_DEF,
	localparam int IDX_W       = $clog2(TAG_ENTRIES)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire alloc_t           alloc,
	input  wire upd_t             upd,
	input  wire logic [IDX_W-1:0] rd_idx,
	output logic      [IDX_W-1:0] free_idx,
	output tbl_stat_t             stat
);

	logic [TAG_ENTRIES-1:0]                   valid_q;
	logic [CTAG_W-1:0]                        core_tag_q   [TAG_ENTRIES];
	logic [LANES-1:0]                         waiting_q    [TAG_ENTRIES];
	logic [SLOTS-1:0][LANES-1:0]              slot_lanes_q [TAG_ENTRIES];
	logic                                     free_found;
	logic [LANES-1:0]                         left;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TAG_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	always_comb begin
		stat.free_found    = free_found;
		stat.rd_valid      = valid_q[rd_idx];
		stat.rd_waiting    = waiting_q[rd_idx];
		stat.rd_core_tag   = core_tag_q[rd_idx];
		stat.rd_slot_lanes = slot_lanes_q[rd_idx];
	end

	assign left = waiting_q[rd_idx] & ~upd.served;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (alloc.en) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (upd.en && left == '0) begin
				valid_q[rd_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (alloc.en) begin
			core_tag_q[free_idx]   <= alloc.core_tag;
			waiting_q[free_idx]    <= alloc.waiting;
			slot_lanes_q[free_idx] <= alloc.slot_lanes;
		end
		if (upd.en) begin
			waiting_q[rd_idx] <= left;
		end
	end

endmodule

`default_nettype wire

// ----- src/gpu_memory_coalescer.sv -----
// ----------------------------------------------------------------------------
// gpu_memory_coalescer - vector lane memory access coalescer
// Groups lane addresses by cache line into memory requests, tracks read tags
// and fans memory responses back out to the waiting lanes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one beat per core request (s_tuser 0) or memory response
//   (s_tuser 1). m_* returns exactly one result beat per input beat; m_tuser
//   is the result kind (stall, memory request, lane response, error).
//   A request with more than two distinct lines leaves lanes unsent; offer
//   the same beat again until the consumed bit is set.
//   Latency: a taken beat is registered in the input register, processed in one
//   pass and its result is presented from the result register. Throughput: one
//   beat per cycle while the receiver does not stall.
//   cfg_wr_en/cfg_wr_data write the line offset width; write only when idle.
//   Reset clears the tag table valid bits, the sent-lane record and the
//   pipeline; the line offset width returns to 6.
//   When the receiver stalls, the result register holds, then the input
//   register holds and s_tready drops; no beat is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module gpu_memory_coalescer
	import gmc_pkg::*;
#(
	parameter int TAG_ENTRIES = TAG_ENTRIES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [LOB_W-1:0]      cfg_wr_data,   // line_offset_bits
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// lane_mask, lane_addr0..3, is_write, core_tag, rsp_tag, rsp_slot_mask
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic                  s_tuser,       // func
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// consumed, mem_slot_mask, mem_line0, mem_line1, mem_tag, mem_write,
	// resp_lanes, resp_core_tag
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic [1:0]                 m_tuser        // kind
);

	localparam int IDX_W = $clog2(TAG_ENTRIES);

	logic                             valid_s1;
	logic                             func_s1;
	logic [LANES-1:0]                 mask_s1;
	logic [LANES-1:0][ADDR_W-1:0]     addr_s1;
	logic                             wr_s1;
	logic [CTAG_W-1:0]                ctag_s1;
	logic [TAG_W-1:0]                 rtag_s1;
	logic [SLOTS-1:0]                 rsmask_s1;

	logic                             valid_s2;
	logic [OUT_DATA_W-1:0]            data_s2;
	logic [1:0]                       kind_s2;

	logic [LANES-1:0]                 sent_q;
	logic [LOB_W-1:0]                 lob_q;

	logic                             out_free;
	logic                             fire;
	grp_t                             grp;
	alloc_t                           alloc;
	upd_t                             upd;
	tbl_stat_t                        stat;
	logic [IDX_W-1:0]                 free_idx;
	logic [IDX_W-1:0]                 rd_idx;
	logic                             tag_ok;
	logic [LANES-1:0]                 served;
	logic [LANES-1:0]                 sent_nxt;
	logic [LANES-1:0]                 sent_or;
	logic [1:0]                       kind;
	logic                             consumed;
	logic [SLOTS-1:0]                 smask;
	logic [ADDR_W-1:0]                line0;
	logic [ADDR_W-1:0]                line1;
	logic [TAG_W-1:0]                 mtag;
	logic                             mwr;
	logic [LANES-1:0]                 rlanes;
	logic [CTAG_W-1:0]                rctag;
	logic [OUT_DATA_W-1:0]            data_nxt;

	assign out_free = !valid_s2 || m_tready;
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tuser  = kind_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lob_q <= LOB_RESET;
		end else if (cfg_wr_en) begin
			lob_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			func_s1   <= s_tuser;
			mask_s1   <= s_tdata[IN_MASK_LO +: LANES];
			addr_s1   <= s_tdata[IN_ADDR_LO +: LANES*ADDR_W];
			wr_s1     <= s_tdata[IN_WR_BIT];
			ctag_s1   <= s_tdata[IN_CTAG_LO +: CTAG_W];
			rtag_s1   <= s_tdata[IN_RTAG_LO +: TAG_W];
			rsmask_s1 <= s_tdata[IN_SMASK_LO +: SLOTS];
		end
	end

	gmc_lane_grouper u_grouper (
		.mask (mask_s1),
		.sent (sent_q),
		.addr (addr_s1),
		.lob  (lob_q),
		.grp  (grp)
	);

	gmc_pend_table #(
		.TAG_ENTRIES (TAG_ENTRIES)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.alloc    (alloc),
		.upd      (upd),
		.rd_idx   (rd_idx),
		.free_idx (free_idx),
		.stat     (stat)
	);

	assign rd_idx  = IDX_W'(rtag_s1);
	assign tag_ok  = {{(32-TAG_W){1'b0}}, rtag_s1} < 32'(TAG_ENTRIES);
	assign sent_or = sent_q | grp.cur;

	always_comb begin
		served = '0;
		for (int s = 0; s < SLOTS; s++) begin
			if (rsmask_s1[s]) begin
				served = served | stat.rd_slot_lanes[s];
			end
		end
		served = served & stat.rd_waiting;
	end

	always_comb begin
		kind     = KIND_STALL;
		consumed = 1'b0;
		smask    = '0;
		line0    = '0;
		line1    = '0;
		mtag     = '0;
		mwr      = 1'b0;
		rlanes   = '0;
		rctag    = '0;
		sent_nxt = sent_q;
		alloc    = '0;
		upd      = '0;
		if (func_s1) begin
			if (!tag_ok || !stat.rd_valid || stat.rd_waiting == '0) begin
				kind = KIND_RSP_ERR;
			end else begin
				kind       = KIND_RSP;
				rlanes     = served;
				rctag      = stat.rd_core_tag;
				upd.en     = fire;
				upd.served = served;
			end
		end else if (stat.free_found) begin
			kind  = KIND_MEM_REQ;
			smask = grp.slot_valid;
			line0 = grp.line[0];
			line1 = grp.line[1];
			mwr   = wr_s1;
			if (!wr_s1 && grp.cur != '0) begin
				mtag             = TAG_W'(free_idx);
				alloc.en         = fire;
				alloc.core_tag   = ctag_s1;
				alloc.waiting    = grp.cur;
				alloc.slot_lanes = grp.slot_lanes;
			end
			sent_nxt = sent_or;
			if ((mask_s1 & ~sent_or) == '0) begin
				consumed = 1'b1;
				sent_nxt = '0;
			end
		end
	end

	always_comb begin
		data_nxt                          = '0;
		data_nxt[OUT_CONS_BIT]            = consumed;
		data_nxt[OUT_SMASK_LO +: SLOTS]   = smask;
		data_nxt[OUT_LINE0_LO +: ADDR_W]  = line0;
		data_nxt[OUT_LINE1_LO +: ADDR_W]  = line1;
		data_nxt[OUT_MTAG_LO +: TAG_W]    = mtag;
		data_nxt[OUT_MWR_BIT]             = mwr;
		data_nxt[OUT_RLANE_LO +: LANES]   = rlanes;
		data_nxt[OUT_RCTAG_LO +: CTAG_W]  = rctag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				sent_q <= sent_nxt;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_s2 <= kind;
			data_s2 <= data_nxt;
		end
	end

endmodule

`default_nettype wire

// ----- tb/tb_gpu_memory_coalescer.sv -----
// ----------------------------------------------------------------------------
// tb_gpu_memory_coalescer - self-checking bench for the memory coalescer
// Streams core requests and memory responses into the block and keeps its own
// model of the coalescing, the sent-lane record and the pending tag table.
// Each result beat is checked against the prediction made when its input beat
// was taken. Retry requests are re-offered, up to four times, until consumed;
// responses mostly target live tags; the line offset width is swept by phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_gpu_memory_coalescer;
	import gmc_pkg::*;

	localparam int LIMIT = 500000;
	localparam int N_TAGS = TAG_ENTRIES_DEF;

	typedef enum logic [1:0] {SRC_REQ, SRC_RSP_LIVE, SRC_RSP_RAW, SRC_DRAIN} beat_src_t;

	typedef struct packed {
		beat_src_t               src;
		logic                    retry;
		logic                    func;
		logic [LANES-1:0]        mask;
		logic [LANES-1:0][31:0]  addr;
		logic                    wr;
		logic [CTAG_W-1:0]       ctag;
		logic [TAG_W-1:0]        rtag;
		logic [SLOTS-1:0]        smask;
	} coal_beat_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic                    consumed;
		logic [SLOTS-1:0]        smask;
		logic [SLOTS-1:0][31:0]  line;
		logic [TAG_W-1:0]        mtag;
		logic                    mwr;
		logic [LANES-1:0]        rlanes;
		logic [CTAG_W-1:0]       rctag;
	} coal_res_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [LOB_W-1:0]      cfg_wr_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;

	coal_beat_t beat_queue[$];
	coal_res_t  awaited_results[$];

	logic [LANES-1:0]             sent_rec = '0;
	logic                         tbl_valid[N_TAGS] = '{default: 1'b0};
	logic [CTAG_W-1:0]            tbl_ctag[N_TAGS] = '{default: '0};
	logic [LANES-1:0]             tbl_wait[N_TAGS] = '{default: '0};
	logic [SLOTS-1:0][LANES-1:0]  tbl_slots[N_TAGS] = '{default: '0};
	logic [LOB_W-1:0]             lob_cur = LOB_RESET;

	logic       no_idle = 1'b0;
	logic       hold_arm = 1'b0;
	int         hold_cnt = 0;
	int         mismatches = 0;
	int         cycles = 0;

	coal_beat_t cur_beat;
	coal_res_t  drv_res;
	bit         loaded = 1'b0;
	bit         drv_found;
	int         tries = 0;
	int         gap_left = 0;
	int         drv_pick;
	int         drv_t;
	int         stall_left = 0;
	coal_res_t  want;

	gpu_memory_coalescer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic coal_res_t coalesce_step(input coal_beat_t b);
		coal_res_t                   r;
		logic [LANES-1:0]            served;
		logic [LANES-1:0]            act;
		logic [LANES-1:0]            cur;
		logic [31:0]                 amask;
		logic [31:0]                 la;
		logic [SLOTS-1:0][31:0]      lines;
		logic [SLOTS-1:0][LANES-1:0] slot_m;
		int                          nlines;
		int                          free_t;
		bit                          hit;
		r = '0;
		if (b.func) begin
			if (!tbl_valid[b.rtag] || tbl_wait[b.rtag] == '0) begin
				r.kind = KIND_RSP_ERR;
				return r;
			end
			served = '0;
			for (int o = 0; o < SLOTS; o++)
				if (b.smask[o])
					served |= tbl_slots[b.rtag][o];
			served &= tbl_wait[b.rtag];
			r.kind = KIND_RSP;
			r.rlanes = served;
			r.rctag = tbl_ctag[b.rtag];
			tbl_wait[b.rtag] &= ~served;
			if (tbl_wait[b.rtag] == '0)
				tbl_valid[b.rtag] = 1'b0;
			return r;
		end
		free_t = -1;
		for (int i = N_TAGS - 1; i >= 0; i--)
			if (!tbl_valid[i])
				free_t = i;
		if (free_t < 0) begin
			r.kind = KIND_STALL;
			return r;
		end
		amask = 32'hFFFF_FFFF << lob_cur;
		act = b.mask & ~sent_rec;
		lines = '0;
		slot_m = '0;
		nlines = 0;
		cur = '0;
		for (int i = 0; i < LANES; i++) begin
			if (act[i]) begin
				la = b.addr[i] & amask;
				hit = 1'b0;
				for (int g = 0; g < nlines; g++) begin
					if (!hit && lines[g] == la) begin
						slot_m[g][i] = 1'b1;
						hit = 1'b1;
					end
				end
				if (!hit && nlines < SLOTS) begin
					lines[nlines] = la;
					slot_m[nlines][i] = 1'b1;
					nlines++;
				end
			end
		end
		for (int o = 0; o < nlines; o++) begin
			r.smask[o] = 1'b1;
			r.line[o] = lines[o];
			cur |= slot_m[o];
		end
		r.kind = KIND_MEM_REQ;
		r.mwr = b.wr;
		if (!b.wr && cur != '0) begin
			tbl_valid[free_t] = 1'b1;
			tbl_ctag[free_t] = b.ctag;
			tbl_wait[free_t] = cur;
			tbl_slots[free_t] = slot_m;
			r.mtag = free_t[TAG_W-1:0];
		end
		sent_rec |= cur;
		if ((b.mask & ~sent_rec) == '0) begin
			r.consumed = 1'b1;
			sent_rec = '0;
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (mismatches < 200)
			$display("t=%0t mismatch %s: got %h want %h", $time, what, got, exp_val);
		mismatches++;
	endtask

	task automatic push_req(input logic [LANES-1:0] mask, input logic [LANES-1:0][31:0] addr,
			input logic wr, input logic [CTAG_W-1:0] ctag, input logic retry);
		coal_beat_t b;
		b.src = SRC_REQ;
		b.retry = retry;
		b.func = 1'b0;
		b.mask = mask;
		b.addr = addr;
		b.wr = wr;
		b.ctag = ctag;
		b.rtag = TAG_W'($urandom_range(0, N_TAGS - 1));
		b.smask = SLOTS'($urandom_range(0, 3));
		beat_queue.insert(beat_queue.size(), b);
	endtask

	task automatic push_rsp(input beat_src_t src, input logic [TAG_W-1:0] tag,
			input logic [SLOTS-1:0] smask);
		coal_beat_t b;
		b.src = src;
		b.retry = 1'b0;
		b.func = 1'b1;
		b.mask = LANES'($urandom_range(0, 15));
		b.addr = {$urandom, $urandom, $urandom, $urandom};
		b.wr = 1'($urandom_range(0, 1));
		b.ctag = CTAG_W'($urandom_range(0, 255));
		b.rtag = tag;
		b.smask = smask;
		beat_queue.insert(beat_queue.size(), b);
	endtask

	task automatic wait_idle;
		do
			@(negedge clk);
		while (beat_queue.size() != 0 || loaded || awaited_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// driver: one beat in hand, re-offered while a retry request is not consumed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			loaded = 1'b0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				drv_res = coalesce_step(cur_beat);
				awaited_results.insert(awaited_results.size(), drv_res);
				if (cur_beat.retry && !drv_res.consumed && drv_res.kind != KIND_STALL
						&& tries < 4) begin
					tries++;
					gap_left = no_idle ? 0 : $urandom_range(0, 10);
				end else begin
					loaded = 1'b0;
				end
			end
			if (!loaded && beat_queue.size() != 0) begin
				if (beat_queue[0].src == SRC_DRAIN) begin
					if (awaited_results.size() == 0)
						void'(beat_queue.pop_front());
				end else begin
					cur_beat = beat_queue.pop_front();
					loaded = 1'b1;
					tries = 0;
					gap_left = no_idle ? 0 : $urandom_range(0, 10);
					if (cur_beat.src == SRC_RSP_LIVE) begin
						drv_pick = $urandom_range(0, N_TAGS - 1);
						drv_found = 1'b0;
						for (int k = 0; k < N_TAGS; k++) begin
							drv_t = (drv_pick + k) % N_TAGS;
							if (!drv_found && tbl_valid[drv_t] && tbl_wait[drv_t] != '0) begin
								cur_beat.rtag = drv_t[TAG_W-1:0];
								drv_found = 1'b1;
							end
						end
					end
				end
			end
			if (loaded && gap_left == 0) begin
				s_tvalid <= 1'b1;
				s_tuser <= cur_beat.func;
				s_tdata <= {6'b0, cur_beat.smask, cur_beat.rtag, cur_beat.ctag, cur_beat.wr,
					cur_beat.addr, cur_beat.mask};
			end else begin
				s_tvalid <= 1'b0;
				if (loaded)
					gap_left--;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_cnt <= 0;
		else if (hold_arm)
			hold_cnt <= 150;
		else if (hold_cnt != 0)
			hold_cnt <= hold_cnt - 1;
	end

	// monitor: compare each result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					flag_mismatch("result with nothing awaited", 32'(m_tuser), 32'd0);
				end else begin
					want = awaited_results.pop_front();
					if (m_tuser !== want.kind)
						flag_mismatch("kind", 32'(m_tuser), 32'(want.kind));
					if (m_tdata[OUT_CONS_BIT] !== want.consumed)
						flag_mismatch("consumed", 32'(m_tdata[OUT_CONS_BIT]),
							32'(want.consumed));
					if (m_tdata[OUT_SMASK_LO +: SLOTS] !== want.smask)
						flag_mismatch("mem_slot_mask", 32'(m_tdata[OUT_SMASK_LO +: SLOTS]),
							32'(want.smask));
					if (m_tdata[OUT_LINE0_LO +: 32] !== want.line[0])
						flag_mismatch("mem_line0", m_tdata[OUT_LINE0_LO +: 32], want.line[0]);
					if (m_tdata[OUT_LINE1_LO +: 32] !== want.line[1])
						flag_mismatch("mem_line1", m_tdata[OUT_LINE1_LO +: 32], want.line[1]);
					if (m_tdata[OUT_MTAG_LO +: TAG_W] !== want.mtag)
						flag_mismatch("mem_tag", 32'(m_tdata[OUT_MTAG_LO +: TAG_W]),
							32'(want.mtag));
					if (m_tdata[OUT_MWR_BIT] !== want.mwr)
						flag_mismatch("mem_write", 32'(m_tdata[OUT_MWR_BIT]), 32'(want.mwr));
					if (m_tdata[OUT_RLANE_LO +: LANES] !== want.rlanes)
						flag_mismatch("resp_lanes", 32'(m_tdata[OUT_RLANE_LO +: LANES]),
							32'(want.rlanes));
					if (m_tdata[OUT_RCTAG_LO +: CTAG_W] !== want.rctag)
						flag_mismatch("resp_core_tag", 32'(m_tdata[OUT_RCTAG_LO +: CTAG_W]),
							32'(want.rctag));
					if (m_tdata[OUT_DATA_W-1:OUT_RCTAG_LO+CTAG_W] !== '0)
						flag_mismatch("pad bits",
							32'(m_tdata[OUT_DATA_W-1:OUT_RCTAG_LO+CTAG_W]), 32'd0);
				end
				stall_left = no_idle ? 0 : $urandom_range(0, 10);
			end
			if (hold_cnt != 0) begin
				m_tready <= 1'b0;
			end else if (stall_left != 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int                      lob_plan[8];
		int                      lob;
		int                      rsp_pct;
		logic [LANES-1:0][31:0]  a;
		logic [31:0]             base;
		logic [31:0]             lsz;
		logic [LANES-1:0]        m;
		lob_plan = '{2, 12, 0, 15, 6, -1, -1, 9};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		push_req(4'hF, {32'h103C, 32'h1008, 32'h1004, 32'h1000}, 1'b0, 8'hA5, 1'b1);
		push_req(4'hF, {32'hFFFF_FFFF, 32'h80, 32'h40, 32'h0}, 1'b0, 8'h5A, 1'b1);
		push_req(4'hF, {32'hFFFF_FFFF, 32'hFFFF_FFC0, 32'h7F, 32'h0}, 1'b1, 8'hFF, 1'b1);
		push_req(4'h0, {$urandom, $urandom, $urandom, $urandom}, 1'b0, 8'h00, 1'b1);
		push_req(4'hA, {32'h2000, 32'h0, 32'h2010, 32'h0}, 1'b0, 8'h3C, 1'b1);
		push_rsp(SRC_RSP_RAW, 3'd7, 2'b11);
		push_rsp(SRC_RSP_LIVE, 3'd0, 2'b00);
		push_rsp(SRC_RSP_LIVE, 3'd0, 2'b01);
		push_rsp(SRC_RSP_LIVE, 3'd0, 2'b10);
		push_rsp(SRC_RSP_LIVE, 3'd0, 2'b11);
		// partial send, then a different mask that finds some of its lanes already sent
		push_req(4'hF, {32'hC0, 32'h80, 32'h40, 32'h0}, 1'b0, 8'h11, 1'b0);
		push_req(4'h6, {32'hC0, 32'h80, 32'h40, 32'h0}, 1'b0, 8'h22, 1'b0);
		push_req(4'hF, {32'hC0, 32'h80, 32'h40, 32'h0}, 1'b0, 8'h33, 1'b0);
		push_req(4'h3, {32'hC0, 32'h80, 32'h40, 32'h0}, 1'b0, 8'h44, 1'b0);
		push_rsp(SRC_DRAIN, 3'd0, 2'b00);
		// overfill the tag table with single-lane reads, then a store
		for (int i = 0; i < 9; i++)
			push_req(4'h1, {4{32'h100 * i}}, 1'b0, 8'(i), 1'b1);
		push_req(4'h1, {4{32'h4000}}, 1'b1, 8'h77, 1'b1);
		for (int i = 0; i < 3; i++)
			push_rsp(SRC_RSP_LIVE, 3'd0, 2'b11);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			lob = (lob_plan[ph] < 0) ? $urandom_range(0, 15) : lob_plan[ph];
			rsp_pct = (ph == 1) ? 15 : 40;
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= lob[LOB_W-1:0];
			no_idle <= (ph == 2 || ph == 6);
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			lob_cur = lob[LOB_W-1:0];
			lsz = 32'd1 << lob;
			for (int n = 0; n < 160; n++) begin
				if (ph == 4 && n % 20 == 19)
					push_rsp(SRC_DRAIN, 3'd0, 2'b00);
				if ($urandom_range(0, 99) < rsp_pct) begin
					push_rsp(($urandom_range(0, 4) == 0) ? SRC_RSP_RAW : SRC_RSP_LIVE,
						TAG_W'($urandom_range(0, N_TAGS - 1)), SLOTS'($urandom_range(0, 3)));
				end else begin
					base = $urandom;
					if ($urandom_range(0, 19) == 0)
						base = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
					for (int l = 0; l < LANES; l++) begin
						case ($urandom_range(0, 3))
							0: begin
								a[l] = base + $urandom_range(0, 3);
							end
							1: begin
								a[l] = base + lsz * $urandom_range(1, 3);
							end
							2: begin
								a[l] = $urandom;
							end
							default: begin
								a[l] = (l == 0) ? base : a[$urandom_range(0, l - 1)];
							end
						endcase
					end
					m = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'hF;
					push_req(m, a, $urandom_range(0, 3) == 0, CTAG_W'($urandom_range(0, 255)),
						$urandom_range(0, 6) != 0);
				end
			end
			if (ph == 2) begin
				@(posedge clk);
				hold_arm <= 1'b1;
				@(posedge clk);
				hold_arm <= 1'b0;
			end
			wait_idle();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
